### rtl/core/iafv_pkg.sv
// Shared types, constants and helpers for the binary stream frame validator.
// Used by every module under rtl/core; depends on nothing else.
package iafv_pkg;

    localparam int unsigned HEADER_BYTES = 64;
    localparam int HDR_POS_W  = $clog2(HEADER_BYTES);
    localparam int HDR_WORD_W = HDR_POS_W - 2;

    localparam logic [HDR_WORD_W-1:0] W_RECEIVER = HDR_WORD_W'(0);
    localparam logic [HDR_WORD_W-1:0] W_RATE     = HDR_WORD_W'(1);
    localparam logic [HDR_WORD_W-1:0] W_FORMAT   = HDR_WORD_W'(2);
    localparam logic [HDR_WORD_W-1:0] W_COUNT    = HDR_WORD_W'(5);
    localparam logic [HDR_WORD_W-1:0] W_TYPE     = HDR_WORD_W'(6);
    localparam logic [HDR_WORD_W-1:0] W_CHANNELS = HDR_WORD_W'(7);

    localparam logic [31:0] HDR_BYTES_32  = 32'(HEADER_BYTES);
    localparam logic [33:0] HDR_BYTES_34  = 34'(HEADER_BYTES);
    localparam logic [31:0] RATE_MIN      = 32'd8000;
    localparam logic [31:0] RATE_MAX      = 32'd10000000;
    localparam logic [31:0] WANT_CHANNELS = 32'd2;
    localparam logic [31:0] CHRONO_TYPE   = 32'd3;
    localparam logic [31:0] MAX_TYPE      = 32'd3;
    localparam logic [31:0] COUNT_SAT     = 32'hFFFF_FFFF;
    localparam logic [7:0]  EXP_ALL_ONES  = 8'hFF;

    localparam logic [7:0]  RST_MAX_RX    = 8'd8;
    localparam logic [31:0] RST_MAX_FRAME = 32'd1048576;
    localparam logic [31:0] RST_FLOAT_FMT = 32'd0;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    typedef enum logic [1:0] {
        CFG_MAX_RX    = 2'd0,
        CFG_MAX_FRAME = 2'd1,
        CFG_FLOAT_FMT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_TOO_LARGE = 4'd2,
        ST_RECEIVER  = 4'd3,
        ST_FORMAT    = 4'd4,
        ST_RATE      = 4'd5,
        ST_CHANNELS  = 4'd6,
        ST_TYPE      = 4'd7,
        ST_LENGTH    = 4'd8,
        ST_NONFINITE = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0]  max_rx;
        logic [31:0] max_frame;
        logic [31:0] float_fmt;
    } t_cfg;

    typedef struct packed {
        logic        has_sample;
        logic [31:0] sample_bits;
        logic        has_verdict;
        logic [31:0] size;
        logic [31:0] receiver;
        logic [31:0] rate;
        logic [31:0] format;
        logic [31:0] count;
        logic [31:0] dtype;
        logic [31:0] channels;
        logic        nonfinite;
    } t_evt;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample_bits;
        logic [31:0] receiver;
        logic [31:0] rate;
        logic [31:0] count;
        logic [1:0]  stype;
        t_status     status;
        logic        eor;
    } t_result;

    function automatic logic [31:0] put_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        w[8*lane +: 8] = b;
        return w;
    endfunction

endpackage

### rtl/core/iafv_front.sv
// Front end: takes frame bytes, gathers the header and assembles payload words.
// Emits one event record per sample or frame end; depends on iafv_pkg.
module iafv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_q_full,
    output logic              o_accept,
    output logic              o_evt_push,
    output iafv_pkg::t_evt    o_evt
);

    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_receiver, n_receiver;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_format, n_format;
    logic [31:0] r_count, n_count;
    logic [31:0] r_type, n_type;
    logic [31:0] r_channels, n_channels;
    logic [23:0] r_partial, n_partial;
    logic        r_saw_nf, n_saw_nf;

    logic [iafv_pkg::HDR_POS_W-1:0]  pos;
    logic [iafv_pkg::HDR_WORD_W-1:0] word;
    logic [1:0]                      pay_lane;
    logic [31:0]                     bits;
    logic                            has_sample;

    assign o_accept = i_push && !i_q_full;
    assign pos      = r_byte_count[iafv_pkg::HDR_POS_W-1:0];
    assign word     = pos[iafv_pkg::HDR_POS_W-1:2];
    assign pay_lane = r_byte_count[1:0] - iafv_pkg::HDR_BYTES_32[1:0];
    assign bits     = {i_data_byte, r_partial};

    always_comb begin
        n_byte_count = r_byte_count;
        n_receiver   = r_receiver;
        n_rate       = r_rate;
        n_format     = r_format;
        n_count      = r_count;
        n_type       = r_type;
        n_channels   = r_channels;
        n_partial    = r_partial;
        n_saw_nf     = r_saw_nf;
        has_sample   = 1'b0;

        if (r_byte_count != iafv_pkg::COUNT_SAT) begin
            n_byte_count = r_byte_count + 32'd1;
            if (r_byte_count < iafv_pkg::HDR_BYTES_32) begin
                unique case (word)
                    iafv_pkg::W_RECEIVER: n_receiver =
                        iafv_pkg::put_lane(r_receiver, pos[1:0], i_data_byte);
                    iafv_pkg::W_RATE:     n_rate =
                        iafv_pkg::put_lane(r_rate, pos[1:0], i_data_byte);
                    iafv_pkg::W_FORMAT:   n_format =
                        iafv_pkg::put_lane(r_format, pos[1:0], i_data_byte);
                    iafv_pkg::W_COUNT:    n_count =
                        iafv_pkg::put_lane(r_count, pos[1:0], i_data_byte);
                    iafv_pkg::W_TYPE:     n_type =
                        iafv_pkg::put_lane(r_type, pos[1:0], i_data_byte);
                    iafv_pkg::W_CHANNELS: n_channels =
                        iafv_pkg::put_lane(r_channels, pos[1:0], i_data_byte);
                    default: ;
                endcase
            end else if (pay_lane != 2'd3) begin
                n_partial = r_partial;
                n_partial[8*pay_lane[1:0] +: 8] = i_data_byte;
            end else begin
                has_sample = 1'b1;
                n_partial  = 24'd0;
                if (bits[30:23] == iafv_pkg::EXP_ALL_ONES) begin
                    n_saw_nf = 1'b1;
                end
            end
        end

        o_evt.has_sample  = has_sample;
        o_evt.sample_bits = bits;
        o_evt.has_verdict = i_last_byte;
        o_evt.size        = n_byte_count;
        o_evt.receiver    = n_receiver;
        o_evt.rate        = n_rate;
        o_evt.format      = n_format;
        o_evt.count       = n_count;
        o_evt.dtype       = n_type;
        o_evt.channels    = n_channels;
        o_evt.nonfinite   = n_saw_nf;

        if (i_last_byte) begin
            n_byte_count = 32'd0;
            n_receiver   = 32'd0;
            n_rate       = 32'd0;
            n_format     = 32'd0;
            n_count      = 32'd0;
            n_type       = 32'd0;
            n_channels   = 32'd0;
            n_partial    = 24'd0;
            n_saw_nf     = 1'b0;
        end
    end

    assign o_evt_push = o_accept && (has_sample || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 32'd0;
            r_receiver   <= 32'd0;
            r_rate       <= 32'd0;
            r_format     <= 32'd0;
            r_count      <= 32'd0;
            r_type       <= 32'd0;
            r_channels   <= 32'd0;
            r_partial    <= 24'd0;
            r_saw_nf     <= 1'b0;
        end else if (o_accept) begin
            r_byte_count <= n_byte_count;
            r_receiver   <= n_receiver;
            r_rate       <= n_rate;
            r_format     <= n_format;
            r_count      <= n_count;
            r_type       <= n_type;
            r_channels   <= n_channels;
            r_partial    <= n_partial;
            r_saw_nf     <= n_saw_nf;
        end
    end

endmodule

### rtl/core/iafv_evt_queue.sv
// Two-entry queue of event records between the front and back ends.
// Depends on iafv_pkg for the record type.
module iafv_evt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iafv_pkg::t_evt i_evt,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output iafv_pkg::t_evt o_head
);

    iafv_pkg::t_evt r_mem [2];
    logic [1:0]     r_cnt;
    logic           r_wr;
    logic           r_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### rtl/core/iafv_back.sv
// Back end: judges frame-end records and queues sample and verdict results.
// Depends on iafv_pkg; fed by iafv_evt_queue.
module iafv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iafv_pkg::t_cfg    i_cfg,
    input  logic              i_q_empty,
    input  iafv_pkg::t_evt    i_evt,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output iafv_pkg::t_result o_res
);

    iafv_pkg::t_result r_mem [iafv_pkg::OUTQ_DEPTH];
    logic [iafv_pkg::OUTQ_PTR_W:0]   r_cnt;
    logic [iafv_pkg::OUTQ_PTR_W-1:0] r_wr;
    logic [iafv_pkg::OUTQ_PTR_W-1:0] r_rd;

    iafv_pkg::t_status status;
    iafv_pkg::t_result res_sample, res_verdict, res0;
    logic [33:0]       expected;
    logic [1:0]        nres;
    logic              take;
    logic              both;
    logic              out_pop;

    assign expected = {i_evt.count, 2'b00} + iafv_pkg::HDR_BYTES_34;

    always_comb begin
        priority if (i_evt.size < iafv_pkg::HDR_BYTES_32) begin
            status = iafv_pkg::ST_SHORT;
        end else if (i_evt.size > i_cfg.max_frame) begin
            status = iafv_pkg::ST_TOO_LARGE;
        end else if (i_cfg.max_rx == 8'd0
                     || i_evt.receiver >= {24'd0, i_cfg.max_rx}) begin
            status = iafv_pkg::ST_RECEIVER;
        end else if (i_evt.format != i_cfg.float_fmt) begin
            status = iafv_pkg::ST_FORMAT;
        end else if (i_evt.rate < iafv_pkg::RATE_MIN
                     || i_evt.rate > iafv_pkg::RATE_MAX) begin
            status = iafv_pkg::ST_RATE;
        end else if (i_evt.channels != iafv_pkg::WANT_CHANNELS) begin
            status = iafv_pkg::ST_CHANNELS;
        end else if (i_evt.dtype > iafv_pkg::MAX_TYPE) begin
            status = iafv_pkg::ST_TYPE;
        end else if ((i_evt.dtype == iafv_pkg::CHRONO_TYPE)
                     ? (i_evt.size != iafv_pkg::HDR_BYTES_32)
                     : (expected != {2'b00, i_evt.size})) begin
            status = iafv_pkg::ST_LENGTH;
        end else if (i_evt.nonfinite) begin
            status = iafv_pkg::ST_NONFINITE;
        end else begin
            status = iafv_pkg::ST_OK;
        end
    end

    always_comb begin
        both = i_evt.has_sample && i_evt.has_verdict;

        res_sample             = '0;
        res_sample.kind        = iafv_pkg::KIND_SAMPLE;
        res_sample.sample_bits = i_evt.sample_bits;
        res_sample.status      = iafv_pkg::ST_OK;
        res_sample.eor         = !both;

        res_verdict             = '0;
        res_verdict.kind        = iafv_pkg::KIND_VERDICT;
        res_verdict.receiver    = i_evt.receiver;
        res_verdict.rate        = i_evt.rate;
        res_verdict.count       = i_evt.count;
        res_verdict.stype       = (status == iafv_pkg::ST_OK) ? i_evt.dtype[1:0] : 2'd0;
        res_verdict.status      = status;
        res_verdict.eor         = 1'b1;

        res0 = i_evt.has_sample ? res_sample : res_verdict;
        nres = {1'b0, i_evt.has_sample} + {1'b0, i_evt.has_verdict};
    end

    assign take    = !i_q_empty
                     && ((3'(iafv_pkg::OUTQ_DEPTH) - r_cnt) >= {1'b0, nres});
    assign o_q_pop = take;
    assign o_empty = (r_cnt == '0);
    assign out_pop = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mem[r_wr] <= res0;
            if (both) begin
                r_mem[r_wr + 1'b1] <= res_verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
        end else begin
            if (take) begin
                r_wr <= r_wr + nres[iafv_pkg::OUTQ_PTR_W-1:0];
            end
            if (out_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (take ? {1'b0, nres} : 3'd0) - {2'b00, out_pop};
        end
    end

endmodule

### rtl/core/iq_audio_frame_validator_core.sv
// Top level of the binary stream frame validator: config registers and wiring.
// Instantiates iafv_front, iafv_evt_queue and iafv_back; depends on iafv_pkg.
//
// Takes one frame byte per cycle while full is low; a frame's 64-byte header
// is gathered, each payload float leaves as a sample result as soon as its
// fourth byte arrives, and the final byte adds a verdict carrying header words
// and status. Samples leave before the verdict, so drop them when the status is
// not ok. A byte that completes a sample and ends the frame yields two results;
// the result side delivers one result per cycle, so full only rises when
// results are not popped. A result reaches the outputs through a two-entry
// event queue and then a four-entry result queue.
module iq_audio_frame_validator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [31:0] o_sample_bits,
    output logic [31:0] o_receiver_number,
    output logic [31:0] o_rate_hz,
    output logic [31:0] o_declared_count,
    output logic [1:0]  o_stream_type,
    output logic [3:0]  o_status,
    output logic        o_end_of_run,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data
);

    iafv_pkg::t_cfg    r_cfg;
    iafv_pkg::t_evt    front_evt, head_evt;
    iafv_pkg::t_result res;
    logic              front_accept;
    logic              evt_push;
    logic              q_full, q_empty, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_rx    <= iafv_pkg::RST_MAX_RX;
            r_cfg.max_frame <= iafv_pkg::RST_MAX_FRAME;
            r_cfg.float_fmt <= iafv_pkg::RST_FLOAT_FMT;
        end else if (i_cfg_wr_en) begin
            unique case (iafv_pkg::t_cfg_idx'(i_cfg_addr))
                iafv_pkg::CFG_MAX_RX:    r_cfg.max_rx    <= i_cfg_wr_data[7:0];
                iafv_pkg::CFG_MAX_FRAME: r_cfg.max_frame <= i_cfg_wr_data;
                iafv_pkg::CFG_FLOAT_FMT: r_cfg.float_fmt <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    iafv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_accept    (front_accept),
        .o_evt_push  (evt_push),
        .o_evt       (front_evt)
    );

    iafv_evt_queue u_evt_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_evt   (front_evt),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_evt)
    );

    iafv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_evt     (head_evt),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign full              = !front_accept && push ? 1'b1 : q_full;
    assign o_result_kind     = res.kind;
    assign o_sample_bits     = res.sample_bits;
    assign o_receiver_number = res.receiver;
    assign o_rate_hz         = res.rate;
    assign o_declared_count  = res.count;
    assign o_stream_type     = res.stype;
    assign o_status          = res.status;
    assign o_end_of_run      = res.eor;

endmodule

### rtl/core/iafv_checker.sv
// Port-level checker for the frame validator core, with its bind statement.
// Sees only the top-level ports; takes status codes from iafv_pkg.
module iafv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        o_result_kind,
    input logic [31:0] o_receiver_number,
    input logic [1:0]  o_stream_type,
    input logic [3:0]  o_status,
    input logic        o_end_of_run
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_sample_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result_kind) |-> (o_status == iafv_pkg::ST_OK
                                         && o_stream_type == 2'd0
                                         && o_receiver_number == 32'd0))
        else $error("sample result carries verdict fields");

    a_verdict_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind) |-> o_end_of_run)
        else $error("verdict without end of run");

    a_type_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != iafv_pkg::ST_OK) |-> o_stream_type == 2'd0)
        else $error("stream type reported on a failed frame");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= iafv_pkg::ST_NONFINITE)
        else $error("status code out of range");

endmodule

bind iq_audio_frame_validator_core iafv_checker u_iafv_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .o_result_kind     (o_result_kind),
    .o_receiver_number (o_receiver_number),
    .o_stream_type     (o_stream_type),
    .o_status          (o_status),
    .o_end_of_run      (o_end_of_run)
);

### sim/frame_result_checker.sv
`timescale 1ns / 1ps
// Result checker for iq_audio_frame_validator_core: follows accepted bytes and register
// writes, predicts sample and verdict transactions and compares each popped one.
// Depends on iafv_pkg only; instantiated beside the core by tb_top.
module frame_result_checker
    import iafv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_result_kind,
    input  logic [31:0] i_sample_bits,
    input  logic [31:0] i_receiver_number,
    input  logic [31:0] i_rate_hz,
    input  logic [31:0] i_declared_count,
    input  logic [1:0]  i_stream_type,
    input  logic [3:0]  i_status,
    input  logic        i_end_of_run,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_samples,
    output int          o_verdicts,
    output logic [9:0]  o_status_seen
);

    logic [7:0]  lim_rx;
    logic [31:0] lim_frame;
    logic [31:0] lim_fmt;

    logic [31:0] byte_cnt;
    logic [31:0] hdr_rx;
    logic [31:0] hdr_rate;
    logic [31:0] hdr_fmt;
    logic [31:0] hdr_count;
    logic [31:0] hdr_type;
    logic [31:0] hdr_chans;
    logic [23:0] part_word;
    logic        any_nonfinite;

    t_result     awaited_results[$];
    t_result     head;
    int          err_cnt     = 0;
    int          sample_cnt  = 0;
    int          verdict_cnt = 0;
    logic [9:0]  seen_mask   = '0;

    task automatic clear_frame_state();
        byte_cnt      = '0;
        hdr_rx        = '0;
        hdr_rate      = '0;
        hdr_fmt       = '0;
        hdr_count     = '0;
        hdr_type      = '0;
        hdr_chans     = '0;
        part_word     = '0;
        any_nonfinite = 1'b0;
    endtask

    function automatic t_status frame_status(input logic [31:0] size);
        logic [33:0] want_len;
        if (size < HDR_BYTES_32) return ST_SHORT;
        if (size > lim_frame) return ST_TOO_LARGE;
        if (lim_rx == 8'd0 || hdr_rx >= {24'd0, lim_rx}) return ST_RECEIVER;
        if (hdr_fmt != lim_fmt) return ST_FORMAT;
        if (hdr_rate < RATE_MIN || hdr_rate > RATE_MAX) return ST_RATE;
        if (hdr_chans != WANT_CHANNELS) return ST_CHANNELS;
        if (hdr_type > MAX_TYPE) return ST_TYPE;
        if (hdr_type == CHRONO_TYPE) begin
            if (size != HDR_BYTES_32) return ST_LENGTH;
        end else begin
            want_len = HDR_BYTES_34 + {hdr_count, 2'b00};
            if (want_len != {2'b00, size}) return ST_LENGTH;
        end
        if (any_nonfinite) return ST_NONFINITE;
        return ST_OK;
    endfunction

    task automatic track_frame_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] old;
        logic [31:0] offset;
        logic [1:0]  lane;
        logic [31:0] word;
        t_status     st;
        t_result     r;
        old = byte_cnt;
        if (old != COUNT_SAT) begin
            byte_cnt = old + 32'd1;
            if (old < HDR_BYTES_32) begin
                lane = old[1:0];
                case (old[HDR_POS_W-1:2])
                    W_RECEIVER: hdr_rx[8*lane +: 8]    = b;
                    W_RATE:     hdr_rate[8*lane +: 8]  = b;
                    W_FORMAT:   hdr_fmt[8*lane +: 8]   = b;
                    W_COUNT:    hdr_count[8*lane +: 8] = b;
                    W_TYPE:     hdr_type[8*lane +: 8]  = b;
                    W_CHANNELS: hdr_chans[8*lane +: 8] = b;
                    default: ;
                endcase
            end else begin
                offset = old - HDR_BYTES_32;
                lane   = offset[1:0];
                if (lane != 2'd3) begin
                    part_word[8*lane +: 8] = b;
                end else begin
                    word      = {b, part_word};
                    part_word = '0;
                    if (word[30:23] == EXP_ALL_ONES) any_nonfinite = 1'b1;
                    r             = '0;
                    r.kind        = KIND_SAMPLE;
                    r.sample_bits = word;
                    r.status      = ST_OK;
                    r.eor         = !is_last;
                    awaited_results.insert(awaited_results.size(), r);
                    sample_cnt++;
                end
            end
        end
        if (is_last) begin
            st          = frame_status(byte_cnt);
            r           = '0;
            r.kind      = KIND_VERDICT;
            r.receiver  = hdr_rx;
            r.rate      = hdr_rate;
            r.count     = hdr_count;
            r.stype     = (st == ST_OK) ? hdr_type[1:0] : 2'd0;
            r.status    = st;
            r.eor       = 1'b1;
            awaited_results.insert(awaited_results.size(), r);
            verdict_cnt++;
            seen_mask[st] = 1'b1;
            clear_frame_state();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_rx    = RST_MAX_RX;
            lim_frame = RST_MAX_FRAME;
            lim_fmt   = RST_FLOAT_FMT;
            clear_frame_state();
            awaited_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_MAX_RX:    lim_rx    = i_cfg_wr_data[7:0];
                    CFG_MAX_FRAME: lim_frame = i_cfg_wr_data;
                    CFG_FLOAT_FMT: lim_fmt   = i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) track_frame_byte(i_data_byte, i_last_byte);
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction popped with nothing expected");
                    err_cnt++;
                end else begin
                    head = awaited_results.pop_front();
                    check_field("result_kind", 32'(head.kind), 32'(i_result_kind));
                    check_field("sample_bits", head.sample_bits, i_sample_bits);
                    check_field("receiver_number", head.receiver, i_receiver_number);
                    check_field("rate_hz", head.rate, i_rate_hz);
                    check_field("declared_count", head.count, i_declared_count);
                    check_field("stream_type", 32'(head.stype), 32'(i_stream_type));
                    check_field("status", 32'(head.status), 32'(i_status));
                    check_field("end_of_run", 32'(head.eor), 32'(i_end_of_run));
                end
            end
        end
        o_errors      <= err_cnt;
        o_pending     <= awaited_results.size();
        o_samples     <= sample_cnt;
        o_verdicts    <= verdict_cnt;
        o_status_seen <= seen_mask;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for iq_audio_frame_validator_core: clock, reset, register settings,
// directed and random frames with sender idling and receiver stalls, and the verdict.
// Depends on iafv_pkg, the core and frame_result_checker.
module tb_top;
    import iafv_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_BYTES   = 64;
    localparam int NUM_PHASES    = 4;
    localparam logic [31:0] FMT_FLOAT = 32'h3F80_0000;

    typedef enum int {
        FLT_NONE,
        FLT_RECEIVER,
        FLT_FORMAT,
        FLT_RATE,
        FLT_CHANNELS,
        FLT_TYPE,
        FLT_LENGTH,
        FLT_NONFINITE,
        FLT_TAIL
    } t_fault;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        empty;
    logic        pop = 1'b0;
    logic        res_kind;
    logic [31:0] res_sample;
    logic [31:0] res_receiver;
    logic [31:0] res_rate;
    logic [31:0] res_count;
    logic [1:0]  res_stype;
    logic [3:0]  res_status;
    logic        res_eor;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    int          chk_errors;
    int          chk_pending;
    int          chk_samples;
    int          chk_verdicts;
    logic [9:0]  chk_seen;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic        hold_go   = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          cycle_cnt = 0;

    logic [7:0]  frame_q[$];
    logic [7:0]  cur_rx;
    logic [31:0] cur_fmt;
    int          frames_sent  = 0;
    int          bytes_sent   = 0;
    int          settings_cnt = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    iq_audio_frame_validator_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (data_byte),
        .i_last_byte       (last_byte),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (res_kind),
        .o_sample_bits     (res_sample),
        .o_receiver_number (res_receiver),
        .o_rate_hz         (res_rate),
        .o_declared_count  (res_count),
        .o_stream_type     (res_stype),
        .o_status          (res_status),
        .o_end_of_run      (res_eor),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wr_data     (cfg_wr_data)
    );

    frame_result_checker u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_data_byte       (data_byte),
        .i_last_byte       (last_byte),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_result_kind     (res_kind),
        .i_sample_bits     (res_sample),
        .i_receiver_number (res_receiver),
        .i_rate_hz         (res_rate),
        .i_declared_count  (res_count),
        .i_stream_type     (res_stype),
        .i_status          (res_status),
        .i_end_of_run      (res_eor),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wr_data     (cfg_wr_data),
        .o_errors          (chk_errors),
        .o_pending         (chk_pending),
        .o_samples         (chk_samples),
        .o_verdicts        (chk_verdicts),
        .o_status_seen     (chk_seen)
    );

    // hold off popping for a long stretch once requested
    always @(posedge clk) begin
        if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            pop       <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic make_frame(input logic [31:0] rx, rate, fmt, count, dtype, chans,
                              input int n_words, input int bad_word);
        logic [31:0] hdr_words [8];
        logic [31:0] word;
        frame_q.delete();
        foreach (hdr_words[w]) hdr_words[w] = $urandom;
        hdr_words[W_RECEIVER] = rx;
        hdr_words[W_RATE]     = rate;
        hdr_words[W_FORMAT]   = fmt;
        hdr_words[W_COUNT]    = count;
        hdr_words[W_TYPE]     = dtype;
        hdr_words[W_CHANNELS] = chans;
        foreach (hdr_words[w]) begin
            for (int k = 0; k < 4; k++) frame_q.insert(frame_q.size(), hdr_words[w][8*k +: 8]);
        end
        repeat (HEADER_BYTES - 32) frame_q.insert(frame_q.size(), 8'($urandom));
        for (int w = 0; w < n_words; w++) begin
            word = $urandom;
            if (w == bad_word) begin
                word[30:23] = EXP_ALL_ONES;
            end else if (word[30:23] == EXP_ALL_ONES) begin
                word[23] = 1'b0;
            end
            for (int k = 0; k < 4; k++) frame_q.insert(frame_q.size(), word[8*k +: 8]);
        end
    endtask

    task automatic set_limits(input logic [7:0] rx, input logic [31:0] max_frame,
                              input logic [31:0] fmt);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_MAX_RX;
        cfg_wr_data <= {24'd0, rx};
        @(posedge clk);
        cfg_addr    <= CFG_MAX_FRAME;
        cfg_wr_data <= max_frame;
        @(posedge clk);
        cfg_addr    <= CFG_FLOAT_FMT;
        cfg_wr_data <= fmt;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_rx  = rx;
        cur_fmt = fmt;
        settings_cnt++;
    endtask

    task automatic drain_and_settle();
        int waited;
        waited = 0;
        push <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_frame();
        int          pick;
        t_fault      fault;
        int          n_words;
        int          bad_word;
        logic [31:0] rx;
        logic [31:0] rate;
        logic [31:0] fmt;
        logic [31:0] count;
        logic [31:0] dtype;
        logic [31:0] chans;
        pick  = $urandom_range(99);
        fault = (pick >= 65 && pick < 88) ? t_fault'($urandom_range(FLT_TAIL, FLT_RECEIVER))
                                          : FLT_NONE;
        rx    = (cur_rx == 8'd0) ? 32'($urandom_range(3))
                                 : 32'($urandom_range(int'(cur_rx) - 1));
        rate     = 32'($urandom_range(RATE_MAX, RATE_MIN));
        fmt      = cur_fmt;
        chans    = WANT_CHANNELS;
        dtype    = 32'($urandom_range(MAX_TYPE));
        count    = 32'($urandom_range(5));
        n_words  = (dtype == CHRONO_TYPE) ? 0 : int'(count);
        bad_word = -1;
        case (fault)
            FLT_RECEIVER: rx = $urandom;
            FLT_FORMAT:   fmt = cur_fmt ^ (32'd1 << $urandom_range(31));
            FLT_RATE:     rate = $urandom_range(1) ? 32'($urandom_range(RATE_MIN - 1)) : $urandom;
            FLT_CHANNELS: chans = 32'($urandom_range(3));
            FLT_TYPE:     dtype = $urandom;
            FLT_LENGTH:   n_words = n_words + 1;
            FLT_NONFINITE: begin
                if (n_words == 0) begin
                    dtype   = 32'd0;
                    count   = 32'd1;
                    n_words = 1;
                end
                bad_word = $urandom_range(n_words - 1);
            end
            default: ;
        endcase
        make_frame(rx, rate, fmt, count, dtype, chans, n_words, bad_word);
        if (fault == FLT_TAIL) begin
            repeat ($urandom_range(3, 1)) frame_q.insert(frame_q.size(), 8'($urandom));
        end
        if (pick >= 88) begin
            frame_q.delete();
            repeat ($urandom_range(90, 1)) frame_q.insert(frame_q.size(), 8'($urandom));
        end
        send_frame();
    endtask

    initial begin
        int phase_start;
        rst_n       = 1'b0;
        push        = 1'b0;
        data_byte   = '0;
        last_byte   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_MAX_RX;
        cfg_wr_data = '0;
        cur_rx      = RST_MAX_RX;
        cur_fmt     = RST_FLOAT_FMT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one good frame under the reset register values
        make_frame(32'd7, 32'd48000, cur_fmt, 32'd1, 32'd1, WANT_CHANNELS, 1, -1);
        send_frame();
        drain_and_settle();

        set_limits(8'd8, 32'd1048576, FMT_FLOAT);
        frame_q.delete();
        frame_q.insert(frame_q.size(), 8'hFF);
        send_frame();
        make_frame(32'd3, 32'd96000, FMT_FLOAT, 32'd0, 32'd0, WANT_CHANNELS, 0, -1);
        void'(frame_q.pop_back());
        send_frame();
        make_frame(32'd8, 32'd48000, FMT_FLOAT, 32'd1, 32'd1, WANT_CHANNELS, 1, -1);
        send_frame();
        // a count whose byte length wraps 32 bits must still fail the length check
        make_frame(32'd0, 32'd48000, FMT_FLOAT, 32'h4000_0000, 32'd0, WANT_CHANNELS, 0, -1);
        send_frame();
        make_frame(32'd0, RATE_MIN, FMT_FLOAT, 32'd1, 32'd1, WANT_CHANNELS, 1, -1);
        frame_q.insert(frame_q.size(), 8'h00);
        frame_q.insert(frame_q.size(), 8'hFF);
        send_frame();
        make_frame(32'd0, RATE_MAX, FMT_FLOAT, 32'd3, 32'd2, WANT_CHANNELS, 3, 2);
        send_frame();
        drain_and_settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            case (ph)
                0: set_limits(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1: set_limits(8'd0, HDR_BYTES_32, 32'd0);
                2: set_limits(8'd4, 32'd1048576, $urandom);
                3: set_limits(8'd1, 32'd80, FMT_FLOAT);
                default: set_limits(8'($urandom_range(255, 1)), 32'($urandom_range(120, 64)),
                                    $urandom);
            endcase
            if (ph == 2) begin
                hold_go = 1'b1;
                make_frame(32'd0, RATE_MIN, cur_fmt, 32'd8, 32'd0, WANT_CHANNELS, 8, -1);
                send_frame();
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
            drain_and_settle();
        end

        if (chk_pending != 0) $error("%0d expected results never arrived", chk_pending);
        $display("Run covered %0d frames, %0d bytes, %0d register settings, four idle profiles",
                 frames_sent, bytes_sent, settings_cnt);
        $display("Checked %0d sample and %0d verdict transactions; status codes seen %b",
                 chk_samples, chk_verdicts, chk_seen);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
